// File: rtl/differential_drive_wheel_mixer_assert.svh
// Assertion macros shared by the wheel mixer checkers.
`ifndef DIFFERENTIAL_DRIVE_WHEEL_MIXER_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_WHEEL_MIXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDWM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DDWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// File: rtl/ddwm_pkg.sv
// Shared types, constants and width helpers for the wheel mixer.
package ddwm_pkg;

    localparam int SPEED_WIDTH_DEF = 16;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_HALF_WHEEL_BASE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_WHEEL_SPEED = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_GAIN       = 2'd2;

    localparam int HWB_W  = 16;
    localparam int MWS_W  = 15;
    localparam int GAIN_W = 16;

    localparam logic [HWB_W-1:0]  HWB_RESET  = 16'd2884;
    localparam logic [MWS_W-1:0]  MWS_RESET  = 15'd4096;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

    localparam int BASE_SHIFT = 16;
    localparam int GAIN_FRAC  = 14;
    localparam int MAX_SHIFT  = 30;

    localparam int            QUOT_W      = 8;
    localparam logic [7:0]    CODE_OFFSET = 8'h80;

    typedef struct packed {
        logic [HWB_W-1:0]  half_wheel_base;
        logic [MWS_W-1:0]  max_wheel_speed;
        logic [GAIN_W-1:0] left_gain;
    } cfg_t;

    // magnitude width of a wheel speed before gain
    function automatic int mag_width(input int speed_w);
        return speed_w + HWB_W + 1;
    endfunction

    // width of gained speeds and of the full scale value
    function automatic int val_width(input int speed_w);
        int a;
        int b;
        a = mag_width(speed_w) + GAIN_W;
        b = MWS_W + MAX_SHIFT;
        return (a > b) ? a : b;
    endfunction

    // width of the dividend 255 * (D + v) + D
    function automatic int num_width(input int speed_w);
        return val_width(speed_w) + QUOT_W + 1;
    endfunction

endpackage

// File: rtl/ddwm_mix.sv
// Wheel speed mixing: turn arm product, left/right sums, gain and alignment.
module ddwm_mix
    import ddwm_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
)(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cfg_t                                 cfg,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [SPEED_WIDTH-1:0]        linear_speed,
    input  logic signed [SPEED_WIDTH-1:0]        turn_rate,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [val_width(SPEED_WIDTH)-1:0]    left_mag,
    output logic [val_width(SPEED_WIDTH)-1:0]    right_mag,
    output logic                                 left_neg,
    output logic                                 right_neg
);

    localparam int MAG_W = mag_width(SPEED_WIDTH);
    localparam int VW    = val_width(SPEED_WIDTH);
    localparam int SUM_W = MAG_W + 1;
    localparam int GL_W  = MAG_W + GAIN_W;

    logic en1;
    logic en2;
    logic en3;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    logic signed [SPEED_WIDTH-1:0] lin1_reg;
    logic signed [MAG_W-1:0]       arm1_reg;
    logic signed [MAG_W-1:0]       arm_next;

    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] arm_ext;
    logic signed [SUM_W-1:0] vl;
    logic signed [SUM_W-1:0] vr;
    logic [SUM_W-1:0]        vl_abs;
    logic [SUM_W-1:0]        vr_abs;
    logic [MAG_W-1:0]        ml2_reg;
    logic [MAG_W-1:0]        mr2_reg;
    logic                    nl2_reg;
    logic                    nr2_reg;

    logic [MAG_W+GAIN_W-1:0]    gl_next;
    logic [MAG_W+GAIN_FRAC-1:0] gr_next;
    logic [VW-1:0]              gl3_reg;
    logic [VW-1:0]              gr3_reg;
    logic                       nl3_reg;
    logic                       nr3_reg;

    assign en3      = !v3_reg || !out_stall;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    assign arm_next = MAG_W'(turn_rate) * MAG_W'($signed({1'b0, cfg.half_wheel_base}));

    assign base    = $signed({{2{lin1_reg[SPEED_WIDTH-1]}}, lin1_reg, {BASE_SHIFT{1'b0}}});
    assign arm_ext = $signed({arm1_reg[MAG_W-1], arm1_reg});
    assign vl      = base - arm_ext;
    assign vr      = base + arm_ext;
    assign vl_abs  = vl[SUM_W-1] ? SUM_W'(-vl) : SUM_W'(vl);
    assign vr_abs  = vr[SUM_W-1] ? SUM_W'(-vr) : SUM_W'(vr);

    assign gl_next = GL_W'(ml2_reg) * GL_W'(cfg.left_gain);
    assign gr_next = {mr2_reg, {GAIN_FRAC{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            lin1_reg <= linear_speed;
            arm1_reg <= arm_next;
        end
        if (en2)
        begin
            ml2_reg <= vl_abs[MAG_W-1:0];
            mr2_reg <= vr_abs[MAG_W-1:0];
            nl2_reg <= vl[SUM_W-1];
            nr2_reg <= vr[SUM_W-1];
        end
        if (en3)
        begin
            gl3_reg <= VW'(gl_next);
            gr3_reg <= VW'(gr_next);
            nl3_reg <= nl2_reg;
            nr3_reg <= nr2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign left_mag  = gl3_reg;
    assign right_mag = gr3_reg;
    assign left_neg  = nl3_reg;
    assign right_neg = nr3_reg;

endmodule

// File: rtl/ddwm_norm.sv
// Full scale selection and dividend forming for the code division.
module ddwm_norm
    import ddwm_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
)(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cfg_t                                 cfg,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [val_width(SPEED_WIDTH)-1:0]    left_mag,
    input  logic [val_width(SPEED_WIDTH)-1:0]    right_mag,
    input  logic                                 left_neg,
    input  logic                                 right_neg,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [val_width(SPEED_WIDTH)-1:0]    den,
    output logic [num_width(SPEED_WIDTH)-1:0]    left_num,
    output logic [num_width(SPEED_WIDTH)-1:0]    right_num
);

    localparam int VW = val_width(SPEED_WIDTH);
    localparam int AW = VW + 1;
    localparam int NW = num_width(SPEED_WIDTH);

    logic en4;
    logic en5;
    logic en6;
    logic en7;

    logic v4_reg;
    logic v5_reg;
    logic v6_reg;
    logic v7_reg;

    logic [VW-1:0] dlr4_reg;
    logic [VW-1:0] gl4_reg;
    logic [VW-1:0] gr4_reg;
    logic          nl4_reg;
    logic          nr4_reg;

    logic [MWS_W-1:0] mws_nz;
    logic [VW-1:0]    d0;
    logic [VW-1:0]    d5_reg;
    logic [VW-1:0]    gl5_reg;
    logic [VW-1:0]    gr5_reg;
    logic             nl5_reg;
    logic             nr5_reg;

    logic [AW-1:0] al_next;
    logic [AW-1:0] ar_next;
    logic [AW-1:0] al6_reg;
    logic [AW-1:0] ar6_reg;
    logic [VW-1:0] d6_reg;

    logic [NW-1:0] nl_next;
    logic [NW-1:0] nr_next;
    logic [NW-1:0] nl7_reg;
    logic [NW-1:0] nr7_reg;
    logic [VW-1:0] d7_reg;

    assign en7      = !v7_reg || !out_stall;
    assign en6      = !v6_reg || en7;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign in_stall = !en4;

    assign mws_nz = (cfg.max_wheel_speed == '0) ? MWS_W'(1) : cfg.max_wheel_speed;
    assign d0     = VW'({mws_nz, {MAX_SHIFT{1'b0}}});

    assign al_next = nl5_reg ? (AW'(d5_reg) - AW'(gl5_reg)) : (AW'(d5_reg) + AW'(gl5_reg));
    assign ar_next = nr5_reg ? (AW'(d5_reg) - AW'(gr5_reg)) : (AW'(d5_reg) + AW'(gr5_reg));

    // 255 * a + D as (a << 8) - a + D
    assign nl_next = NW'({al6_reg, {QUOT_W{1'b0}}}) - NW'(al6_reg) + NW'(d6_reg);
    assign nr_next = NW'({ar6_reg, {QUOT_W{1'b0}}}) - NW'(ar6_reg) + NW'(d6_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (en4)
            begin
                v4_reg <= in_valid;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
            if (en6)
            begin
                v6_reg <= v5_reg;
            end
            if (en7)
            begin
                v7_reg <= v6_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            dlr4_reg <= (left_mag > right_mag) ? left_mag : right_mag;
            gl4_reg  <= left_mag;
            gr4_reg  <= right_mag;
            nl4_reg  <= left_neg;
            nr4_reg  <= right_neg;
        end
        if (en5)
        begin
            d5_reg  <= (dlr4_reg > d0) ? dlr4_reg : d0;
            gl5_reg <= gl4_reg;
            gr5_reg <= gr4_reg;
            nl5_reg <= nl4_reg;
            nr5_reg <= nr4_reg;
        end
        if (en6)
        begin
            al6_reg <= al_next;
            ar6_reg <= ar_next;
            d6_reg  <= d5_reg;
        end
        if (en7)
        begin
            nl7_reg <= nl_next;
            nr7_reg <= nr_next;
            d7_reg  <= d6_reg;
        end
    end

    assign out_valid = v7_reg;
    assign den       = d7_reg;
    assign left_num  = nl7_reg;
    assign right_num = nr7_reg;

endmodule

// File: rtl/ddwm_div.sv
// Pipelined restoring divider: one code bit per stage for both wheels.
module ddwm_div
    import ddwm_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
)(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [val_width(SPEED_WIDTH)-1:0]    den,
    input  logic [num_width(SPEED_WIDTH)-1:0]    left_num,
    input  logic [num_width(SPEED_WIDTH)-1:0]    right_num,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [7:0]                           left_code,
    output logic [7:0]                           right_code
);

    localparam int VW = val_width(SPEED_WIDTH);
    localparam int NW = num_width(SPEED_WIDTH);

    logic [QUOT_W-1:0] vld_reg;
    logic [QUOT_W-1:0] en;

    logic [QUOT_W-1:0] ql_reg [QUOT_W];
    logic [QUOT_W-1:0] qr_reg [QUOT_W];
    logic [NW-1:0]     rl_reg [QUOT_W-1];
    logic [NW-1:0]     rr_reg [QUOT_W-1];
    logic [VW-1:0]     d_reg  [QUOT_W-1];

    genvar k;
    generate
        for (k = 0; k < QUOT_W; k++)
        begin : g_stage
            localparam int B = QUOT_W - 1 - k;

            logic              v_in;
            logic [NW-1:0]     rl_in;
            logic [NW-1:0]     rr_in;
            logic [VW-1:0]     d_in;
            logic [QUOT_W-1:0] ql_in;
            logic [QUOT_W-1:0] qr_in;
            logic [NW-1:0]     trial;
            logic              ge_l;
            logic              ge_r;

            if (k == 0)
            begin : g_first
                assign v_in  = in_valid;
                assign rl_in = left_num;
                assign rr_in = right_num;
                assign d_in  = den;
                assign ql_in = '0;
                assign qr_in = '0;
            end
            else
            begin : g_next
                assign v_in  = vld_reg[k-1];
                assign rl_in = rl_reg[k-1];
                assign rr_in = rr_reg[k-1];
                assign d_in  = d_reg[k-1];
                assign ql_in = ql_reg[k-1];
                assign qr_in = qr_reg[k-1];
            end

            if (k == QUOT_W - 1)
            begin : g_last_en
                assign en[k] = !vld_reg[k] || !out_stall;
            end
            else
            begin : g_mid_en
                assign en[k] = !vld_reg[k] || en[k+1];
            end

            // compare against 2 * D * 2^B
            assign trial = NW'(d_in) << (B + 1);
            assign ge_l  = rl_in >= trial;
            assign ge_r  = rr_in >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en[k])
                begin
                    vld_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    ql_reg[k] <= ql_in | (QUOT_W'(ge_l) << B);
                    qr_reg[k] <= qr_in | (QUOT_W'(ge_r) << B);
                end
            end

            if (k < QUOT_W - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en[k])
                    begin
                        rl_reg[k] <= ge_l ? (rl_in - trial) : rl_in;
                        rr_reg[k] <= ge_r ? (rr_in - trial) : rr_in;
                        d_reg[k]  <= d_in;
                    end
                end
            end
        end
    endgenerate

    assign in_stall   = !en[0];
    assign out_valid  = vld_reg[QUOT_W-1];
    assign left_code  = ql_reg[QUOT_W-1] + CODE_OFFSET;
    assign right_code = qr_reg[QUOT_W-1] + CODE_OFFSET;

endmodule

// File: rtl/differential_drive_wheel_mixer.sv
// Top level of the differential drive wheel mixer.
//
// Input channel: in_valid/in_stall with linear_speed and turn_rate (signed Q4.12).
// Output channel: out_valid/out_stall with left_code and right_code drive bytes.
// A beat moves on a rising edge with valid high and stall low.
// Configuration: cfg_we with cfg_index selects half_wheel_base (0),
// max_wheel_speed (1) or left_gain (2); other indexes are dropped.
// Write configuration only while no beat is in flight.
// An input beat passes the mix, scaling and divider stages in that order.
// Throughput: one beat per cycle while the output is not stalled; 3 mix stages,
// 4 scaling stages and an 8-stage divider producing one code bit per stage.
// Reset clears all stage valid bits and loads the register defaults; no
// clearing pass is needed, so input is taken in the first cycle after reset.
// When the receiver stalls, a valid output holds, stages behind it fill
// their bubbles, and in_stall rises only once every stage holds a beat.
module differential_drive_wheel_mixer
    import ddwm_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SPEED_WIDTH-1:0] linear_speed,
    input  logic signed [SPEED_WIDTH-1:0] turn_rate,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    left_code,
    output logic [7:0]                    right_code
);

    localparam int VW = val_width(SPEED_WIDTH);
    localparam int NW = num_width(SPEED_WIDTH);

    cfg_t cfg_reg;

    logic          mix_valid;
    logic          mix_stall;
    logic [VW-1:0] mix_left_mag;
    logic [VW-1:0] mix_right_mag;
    logic          mix_left_neg;
    logic          mix_right_neg;

    logic          norm_valid;
    logic          norm_stall;
    logic [VW-1:0] norm_den;
    logic [NW-1:0] norm_left_num;
    logic [NW-1:0] norm_right_num;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_wheel_base <= HWB_RESET;
            cfg_reg.max_wheel_speed <= MWS_RESET;
            cfg_reg.left_gain       <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HALF_WHEEL_BASE: cfg_reg.half_wheel_base <= cfg_data[HWB_W-1:0];
                REG_MAX_WHEEL_SPEED: cfg_reg.max_wheel_speed <= cfg_data[MWS_W-1:0];
                REG_LEFT_GAIN:       cfg_reg.left_gain       <= cfg_data[GAIN_W-1:0];
                default:             ;
            endcase
        end
    end

    ddwm_mix #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_mix (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .linear_speed (linear_speed),
        .turn_rate    (turn_rate),
        .out_valid    (mix_valid),
        .out_stall    (mix_stall),
        .left_mag     (mix_left_mag),
        .right_mag    (mix_right_mag),
        .left_neg     (mix_left_neg),
        .right_neg    (mix_right_neg)
    );

    ddwm_norm #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (mix_valid),
        .in_stall  (mix_stall),
        .left_mag  (mix_left_mag),
        .right_mag (mix_right_mag),
        .left_neg  (mix_left_neg),
        .right_neg (mix_right_neg),
        .out_valid (norm_valid),
        .out_stall (norm_stall),
        .den       (norm_den),
        .left_num  (norm_left_num),
        .right_num (norm_right_num)
    );

    ddwm_div #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (norm_valid),
        .in_stall   (norm_stall),
        .den        (norm_den),
        .left_num   (norm_left_num),
        .right_num  (norm_right_num),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .left_code  (left_code),
        .right_code (right_code)
    );

endmodule

// File: rtl/ddwm_check.sv
// Port-level checker for the wheel mixer, bound to the top level.
`include "differential_drive_wheel_mixer_assert.svh"

module ddwm_check (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] left_code,
    input logic [7:0] right_code
);

    // input backs up only when the whole pipe is full behind a stalled output
    `DDWM_ASSERT_SAME(a_stall_needs_full, clk, rst_n, in_stall, out_valid && out_stall)
    // a full pipe with a stalled output stays full
    `DDWM_ASSERT_SAME(a_full_holds, clk, rst_n, in_stall ##1 out_stall, in_stall)
    `DDWM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `DDWM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(left_code) && $stable(right_code))

endmodule

bind differential_drive_wheel_mixer ddwm_check u_ddwm_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .left_code  (left_code),
    .right_code (right_code)
);
